// ===== sv/pressure_temperature_compensation_unit_assert.svh =====
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_UNIT_ASSERT_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define PTCU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptcu assertion failed");

// next-cycle implication, off during reset
`define PTCU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptcu assertion failed");

`endif

// ===== sv/ptcu_pkg.sv =====
package ptcu_pkg;

  localparam int CAL_W     = 16;
  localparam int CAL_IDX_W = 3;
  localparam int RAW_W     = 24;
  localparam int TEMP_W    = 19;
  localparam int PRES_W    = 23;
  localparam int NUM_STG   = 9;

  localparam logic signed [20:0] TEMP_BASE = 21'sd2000;
  localparam logic [TEMP_W-1:0]  TEMP_MAX  = 19'h3FFFF;
  localparam logic [TEMP_W-1:0]  TEMP_MIN  = 19'h40000;
  localparam logic [PRES_W-1:0]  PRES_MAX  = 23'h3FFFFF;
  localparam logic [PRES_W-1:0]  PRES_MIN  = 23'h400000;

  typedef enum logic [CAL_IDX_W-1:0] {
    CAL_PRESSURE_SENSITIVITY   = 3'd0,
    CAL_PRESSURE_OFFSET        = 3'd1,
    CAL_SENSITIVITY_TEMP_COEFF = 3'd2,
    CAL_OFFSET_TEMP_COEFF      = 3'd3,
    CAL_REFERENCE_TEMPERATURE  = 3'd4,
    CAL_TEMPERATURE_COEFF      = 3'd5
  } cal_idx_e;

  typedef struct packed {
    logic [CAL_W-1:0] pressure_sensitivity;
    logic [CAL_W-1:0] pressure_offset;
    logic [CAL_W-1:0] sensitivity_temp_coeff;
    logic [CAL_W-1:0] offset_temp_coeff;
    logic [CAL_W-1:0] reference_temperature;
    logic [CAL_W-1:0] temperature_coeff;
  } cal_t;

endpackage

// ===== sv/pressure_temperature_compensation_unit.sv =====
// Compensates one raw pressure and temperature conversion pair per word, using six 16-bit
// calibration words written on the cfg port (cfg_ready_o is always high; write only while the
// block is idle). Each word gives temperature in hundredths of a degree and compensated pressure,
// both saturated, with the second-order correction below 20.00 degrees. The datapath is a
// nine-stage pipeline: a new word can be taken every cycle while in_ready_o is high. Each stage
// holds when it is full and the stage after it is full and stalled, so empty stages still fill
// while out_ready_i is low.
module pressure_temperature_compensation_unit import ptcu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CAL_IDX_W-1:0] cfg_index_i,
  input  logic [CAL_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [RAW_W-1:0]     raw_pressure_i,
  input  logic [RAW_W-1:0]     raw_temperature_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [TEMP_W-1:0]    temperature_centi_o,
  output logic [PRES_W-1:0]    pressure_value_o
);

  cal_t cal;

  ptcu_cal_regs u_cal_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cal_o       (cal)
  );

  // pipeline control
  logic [NUM_STG-1:0] vld_q, vld_d;
  logic [NUM_STG:0]   rdy;

  always_comb begin
    rdy[NUM_STG] = out_ready_i;
    for (int k = NUM_STG - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    for (int k = 0; k < NUM_STG; k++) begin
      if (rdy[k]) begin
        vld_d[k] = (k == 0) ? in_valid_i : vld_q[(k == 0) ? 0 : k - 1];
      end else begin
        vld_d[k] = vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NUM_STG-1];

  // stage 1: temperature difference
  logic signed [24:0] s1_dt_q, s1_dt_d;
  logic [RAW_W-1:0]   s1_d1_q;

  assign s1_dt_d = $signed({1'b0, raw_temperature_i})
                 - $signed({1'b0, cal.reference_temperature, 8'h00});

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s1_dt_q <= s1_dt_d;
      s1_d1_q <= raw_pressure_i;
    end
  end

  // stage 2: products with dt
  logic signed [41:0] s2_pt_q, s2_pt_d, s2_po_q, s2_po_d, s2_ps_q, s2_ps_d;
  logic signed [49:0] s2_dd_q, s2_dd_d;
  logic [RAW_W-1:0]   s2_d1_q;

  assign s2_pt_d = s1_dt_q * $signed({1'b0, cal.temperature_coeff});
  assign s2_po_d = s1_dt_q * $signed({1'b0, cal.offset_temp_coeff});
  assign s2_ps_d = s1_dt_q * $signed({1'b0, cal.sensitivity_temp_coeff});
  assign s2_dd_d = s1_dt_q * s1_dt_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      s2_pt_q <= s2_pt_d;
      s2_po_q <= s2_po_d;
      s2_ps_q <= s2_ps_d;
      s2_dd_q <= s2_dd_d;
      s2_d1_q <= s1_d1_q;
    end
  end

  // stage 3: first-order temperature, offset, sensitivity
  logic signed [18:0] s3_q_q, s3_q_d;
  logic signed [20:0] s3_temp_q, s3_temp_d;
  logic signed [37:0] s3_off_q, s3_off_d;
  logic signed [36:0] s3_sens_q, s3_sens_d;
  logic [17:0]        s3_ti_q, s3_ti_d;
  logic               s3_cold_q;
  logic [RAW_W-1:0]   s3_d1_q;
  logic [41:0]        pt_bias, po_bias, ps_bias;
  logic [53:0]        dd11;

  always_comb begin
    pt_bias   = s2_pt_q + {19'd0, {23{s2_pt_q[41]}}};
    s3_q_d    = $signed(pt_bias[41:23]);
    s3_temp_d = $signed({{2{s3_q_d[18]}}, s3_q_d}) + TEMP_BASE;
    po_bias   = s2_po_q + {36'd0, {6{s2_po_q[41]}}};
    s3_off_d  = $signed({4'd0, cal.pressure_offset, 17'd0})
              + $signed({{2{po_bias[41]}}, po_bias[41:6]});
    ps_bias   = s2_ps_q + {35'd0, {7{s2_ps_q[41]}}};
    s3_sens_d = $signed({5'd0, cal.pressure_sensitivity, 16'd0})
              + $signed({{2{ps_bias[41]}}, ps_bias[41:7]});
    dd11      = {1'b0, s2_dd_q, 3'b000} + {3'b000, s2_dd_q, 1'b0} + {4'b0000, s2_dd_q};
    s3_ti_d   = dd11[52:35];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      s3_q_q    <= s3_q_d;
      s3_temp_q <= s3_temp_d;
      s3_off_q  <= s3_off_d;
      s3_sens_q <= s3_sens_d;
      s3_ti_q   <= s3_ti_d;
      s3_cold_q <= s3_q_d[18];
      s3_d1_q   <= s2_d1_q;
    end
  end

  // stage 4: square of temperature step, corrected temperature
  logic signed [37:0] s4_qq_q, s4_qq_d;
  logic signed [20:0] s4_temp_q, s4_temp_d;
  logic signed [37:0] s4_off_q;
  logic signed [36:0] s4_sens_q;
  logic               s4_cold_q;
  logic [RAW_W-1:0]   s4_d1_q;

  assign s4_qq_d   = s3_q_q * s3_q_q;
  assign s4_temp_d = s3_cold_q ? s3_temp_q - $signed({3'd0, s3_ti_q}) : s3_temp_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      s4_qq_q   <= s4_qq_d;
      s4_temp_q <= s4_temp_d;
      s4_off_q  <= s3_off_q;
      s4_sens_q <= s3_sens_q;
      s4_cold_q <= s3_cold_q;
      s4_d1_q   <= s3_d1_q;
    end
  end

  // stage 5: second-order offset and sensitivity, temperature saturation
  logic signed [37:0]  s5_off_q, s5_off_d;
  logic signed [36:0]  s5_sens_q, s5_sens_d;
  logic [TEMP_W-1:0]   s5_temp_q, s5_temp_d;
  logic [RAW_W-1:0]    s5_d1_q;
  logic [34:0]         qq;
  logic [39:0]         qq31;
  logic [40:0]         qq63;

  always_comb begin
    qq        = s4_qq_q[34:0];
    qq31      = {qq, 5'd0} - {5'd0, qq};
    qq63      = {qq, 6'd0} - {6'd0, qq};
    s5_off_d  = s4_cold_q ? s4_off_q - $signed({1'b0, qq31[39:3]}) : s4_off_q;
    s5_sens_d = s4_cold_q ? s4_sens_q - $signed({1'b0, qq63[40:5]}) : s4_sens_q;
    if (s4_temp_q[20:18] == 3'b000 || s4_temp_q[20:18] == 3'b111) begin
      s5_temp_d = s4_temp_q[18:0];
    end else if (s4_temp_q[20]) begin
      s5_temp_d = TEMP_MIN;
    end else begin
      s5_temp_d = TEMP_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      s5_off_q  <= s5_off_d;
      s5_sens_q <= s5_sens_d;
      s5_temp_q <= s5_temp_d;
      s5_d1_q   <= s4_d1_q;
    end
  end

  // stage 6: pressure times sensitivity, two partial products
  logic [41:0]        s6_pl_q, s6_pl_d;
  logic signed [43:0] s6_ph_q, s6_ph_d;
  logic signed [37:0] s6_off_q;
  logic [TEMP_W-1:0]  s6_temp_q;

  assign s6_pl_d = s5_d1_q * s5_sens_q[17:0];
  assign s6_ph_d = $signed({1'b0, s5_d1_q}) * $signed(s5_sens_q[36:18]);

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      s6_pl_q   <= s6_pl_d;
      s6_ph_q   <= s6_ph_d;
      s6_off_q  <= s5_off_q;
      s6_temp_q <= s5_temp_q;
    end
  end

  // stage 7: combine partial products
  logic [61:0]        s7_prod_q, s7_prod_d;
  logic signed [37:0] s7_off_q;
  logic [TEMP_W-1:0]  s7_temp_q;

  assign s7_prod_d = {s6_ph_q, 18'd0} + {20'd0, s6_pl_q};

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      s7_prod_q <= s7_prod_d;
      s7_off_q  <= s6_off_q;
      s7_temp_q <= s6_temp_q;
    end
  end

  // stage 8: scale toward zero and remove offset
  logic [41:0]       s8_acc_q, s8_acc_d;
  logic [TEMP_W-1:0] s8_temp_q;
  logic              prod_round;

  always_comb begin
    prod_round = s7_prod_q[61] && (|s7_prod_q[20:0]);
    s8_acc_d   = {s7_prod_q[61], s7_prod_q[61:21]} + {41'd0, prod_round}
               - {{4{s7_off_q[37]}}, s7_off_q};
  end

  always_ff @(posedge clk_i) begin
    if (rdy[7]) begin
      s8_acc_q  <= s8_acc_d;
      s8_temp_q <= s7_temp_q;
    end
  end

  // stage 9: final scaling, saturation, output register
  logic [PRES_W-1:0] pres_q, pres_d;
  logic [TEMP_W-1:0] temp_q;
  logic [26:0]       acc_div;

  always_comb begin
    acc_div = s8_acc_q[41:15] + {26'd0, s8_acc_q[41] && (|s8_acc_q[14:0])};
    if (acc_div[26:22] == 5'b00000 || acc_div[26:22] == 5'b11111) begin
      pres_d = acc_div[22:0];
    end else if (acc_div[26]) begin
      pres_d = PRES_MIN;
    end else begin
      pres_d = PRES_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[8]) begin
      pres_q <= pres_d;
      temp_q <= s8_temp_q;
    end
  end

  assign temperature_centi_o = temp_q;
  assign pressure_value_o    = pres_q;

endmodule

// ===== sv/ptcu_cal_regs.sv =====
module ptcu_cal_regs import ptcu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CAL_IDX_W-1:0] cfg_index_i,
  input  logic [CAL_W-1:0]     cfg_data_i,
  output cal_t                 cal_o
);

  cal_t cal_q, cal_d;

  assign cfg_ready_o = 1'b1;
  assign cal_o       = cal_q;

  always_comb begin
    cal_d = cal_q;
    if (cfg_valid_i) begin
      case (cal_idx_e'(cfg_index_i))
        CAL_PRESSURE_SENSITIVITY:   cal_d.pressure_sensitivity   = cfg_data_i;
        CAL_PRESSURE_OFFSET:        cal_d.pressure_offset        = cfg_data_i;
        CAL_SENSITIVITY_TEMP_COEFF: cal_d.sensitivity_temp_coeff = cfg_data_i;
        CAL_OFFSET_TEMP_COEFF:      cal_d.offset_temp_coeff      = cfg_data_i;
        CAL_REFERENCE_TEMPERATURE:  cal_d.reference_temperature  = cfg_data_i;
        CAL_TEMPERATURE_COEFF:      cal_d.temperature_coeff      = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else begin
      cal_q <= cal_d;
    end
  end

endmodule

// ===== sv/ptcu_checker.sv =====
`include "pressure_temperature_compensation_unit_assert.svh"

module ptcu_checker import ptcu_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cfg_valid_i,
  input logic              cfg_ready_o,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [TEMP_W-1:0] temperature_centi_o,
  input logic [PRES_W-1:0] pressure_value_o
);

  // input only backs up when every stage is full and the output is stalled
  `PTCU_ASSERT_NOW(a_stall_from_output, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)

  // calibration writes are never refused
  `PTCU_ASSERT_NOW(a_cfg_always_ready, clk_i, rst_ni, cfg_valid_i, cfg_ready_o)

  // stalled result word holds
  `PTCU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(temperature_centi_o) && $stable(pressure_value_o))

endmodule

bind pressure_temperature_compensation_unit ptcu_checker u_ptcu_checker (.*);
